[rtl/bpoc_pkg.sv]
package bpoc_pkg;

  localparam int COORD_BITS = 16;
  localparam int IDX_BITS   = 7;
  localparam int SIZE_BITS  = 15;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t left;
    coord_t bottom;
    coord_t right;
    coord_t top;
  } box_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
    logic finish;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic in_range;
    logic hit_now;
  } dp_sts_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Clamps a widened edge sum to the signed coordinate range.
  function automatic coord_t sat_coord(input logic signed [COORD_BITS+1:0] v);
    coord_t res;
    if (v > (COORD_BITS+2)'(COORD_MAX)) begin
      res = COORD_MAX;
    end else if (v < (COORD_BITS+2)'(COORD_MIN)) begin
      res = COORD_MIN;
    end else begin
      res = v[COORD_BITS-1:0];
    end
    return res;
  endfunction

endpackage

[rtl/bpoc_datapath.sv]
module bpoc_datapath
  import bpoc_pkg::*;
#(
  parameter int ENTRIES = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_cmd_t              cmd,
  output dp_sts_t               sts,
  input  logic [IDX_BITS-1:0]   in_entry_index,
  input  coord_t                in_center_x,
  input  coord_t                in_center_y,
  input  logic [SIZE_BITS-1:0]  in_box_width,
  input  logic [SIZE_BITS-1:0]  in_box_height,
  input  logic [IDX_BITS-1:0]   in_range_first,
  input  logic [IDX_BITS-1:0]   in_range_last,
  output logic                  out_placed,
  output coord_t                out_left_edge,
  output coord_t                out_bottom_edge,
  output coord_t                out_right_edge,
  output coord_t                out_top_edge
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SW = ((AW > IDX_BITS) ? AW : IDX_BITS) + 1;
  localparam int MW = SW + IDX_BITS;
  localparam int EW = COORD_BITS + 2;

  box_t mem [ENTRIES];

  box_t                box_r;
  box_t                box_nxt;
  box_t                rd_data_r;
  logic [AW-1:0]       entry_r;
  logic [AW-1:0]       entry_nxt;
  logic [IDX_BITS-1:0] last_r;
  logic [SW-1:0]       cnt_r;
  logic [SW-1:0]       cnt_nxt;
  logic                chk_vld_r;
  logic                chk_vld_nxt;
  logic                placed_r;

  logic [MW-1:0]          rem;
  logic signed [EW-1:0]   cx_w;
  logic signed [EW-1:0]   cy_w;
  logic signed [EW-1:0]   hw_w;
  logic signed [EW-1:0]   hh_w;
  logic                   is_self;
  logic                   x_apart;
  logic                   y_apart;
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  box_t                   mem_wd;

  // Entry index reduced modulo the table depth by restoring subtraction.
  always_comb begin
    rem = MW'(in_entry_index);
    for (int k = IDX_BITS - 1; k >= 0; k--) begin
      if (rem >= (MW'(ENTRIES) << k)) begin
        rem = rem - (MW'(ENTRIES) << k);
      end
    end
    entry_nxt = rem[AW-1:0];
  end

  assign cx_w = EW'(in_center_x);
  assign cy_w = EW'(in_center_y);
  assign hw_w = $signed(EW'(in_box_width >> 1));
  assign hh_w = $signed(EW'(in_box_height >> 1));

  always_comb begin
    box_nxt.left   = sat_coord(cx_w - hw_w);
    box_nxt.right  = sat_coord(cx_w + hw_w);
    box_nxt.bottom = sat_coord(cy_w - hh_w);
    box_nxt.top    = sat_coord(cy_w + hh_w);
  end

  assign sts.in_range   = (cnt_r <= SW'(last_r)) && (cnt_r < SW'(ENTRIES));
  assign sts.clear_done = (cnt_r == SW'(ENTRIES - 1));
  assign is_self        = (cnt_r == SW'(entry_r));

  // Boxes that merely touch are not apart, so the compares are strict.
  assign x_apart = ((box_r.left < rd_data_r.left) && (box_r.right < rd_data_r.left)) ||
                   ((box_r.left > rd_data_r.right) && (box_r.right > rd_data_r.right));
  assign y_apart = ((box_r.bottom < rd_data_r.bottom) && (box_r.top < rd_data_r.bottom)) ||
                   ((box_r.bottom > rd_data_r.top) && (box_r.top > rd_data_r.top));
  assign sts.hit_now = chk_vld_r && !x_apart && !y_apart;

  // A compare is pending only in the cycle right after its table read.
  always_comb begin
    cnt_nxt     = cnt_r;
    chk_vld_nxt = 1'b0;
    if (cmd.load) begin
      cnt_nxt     = SW'(in_range_first);
      chk_vld_nxt = 1'b0;
    end else if (cmd.clear) begin
      cnt_nxt = cnt_r + SW'(1);
    end else if (cmd.scan) begin
      chk_vld_nxt = sts.in_range && !is_self;
      if (sts.in_range) begin
        cnt_nxt = cnt_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      chk_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      chk_vld_r <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      box_r   <= box_nxt;
      entry_r <= entry_nxt;
      last_r  <= in_range_last;
    end
    if (cmd.finish) begin
      placed_r <= !sts.hit_now;
    end
  end

  // One write port shared by the clearing pass and the commit of a placed box.
  assign mem_we = cmd.clear || (cmd.finish && !sts.hit_now);
  assign mem_wa = cmd.clear ? cnt_r[AW-1:0] : entry_r;
  assign mem_wd = cmd.clear ? '0 : box_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[cnt_r[AW-1:0]];
  end

  assign out_placed      = placed_r;
  assign out_left_edge   = box_r.left;
  assign out_bottom_edge = box_r.bottom;
  assign out_right_edge  = box_r.right;
  assign out_top_edge    = box_r.top;

  a_load_clears_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !chk_vld_r)
    else $error("compare pending right after a new request was loaded");

  a_check_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> $past(sts.in_range) && $past(cmd.scan))
    else $error("compare issued without an in-range table read");

endmodule

[rtl/bpoc_ctrl.sv]
module bpoc_ctrl
  import bpoc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_strobe,
  output ctl_cmd_t cmd,
  input  dp_sts_t  sts
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_SCAN  = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   strobe_r;
  logic   strobe_nxt;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        // Stop on the first overlap, or once the range is used up and the
        // last compare has come back clean.
        if (sts.hit_now || !sts.in_range) begin
          cmd.finish = 1'b1;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;

  a_strobe_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == S_SCAN))
    else $error("result word without a finished scan");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result word strobed twice in a row");

  a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_SCAN) && busy)
    else $error("accepted word did not start a scan");

endmodule

[rtl/box_placement_overlap_check_unit.sv]
// Each accepted word scans its entry range one table entry per cycle, stopping at the
// first overlap; a new word is not taken while a scan is running. busy is low in the
// strobe cycle, so the next word may be accepted in that cycle.
// After reset a clearing pass zeroes the table with busy held high.
// Results cannot be stalled: out_strobe is high for exactly one cycle per word.
module box_placement_overlap_check_unit
  import bpoc_pkg::*;
#(
  parameter int ENTRIES = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [IDX_BITS-1:0]   in_entry_index,
  input  coord_t                in_center_x,
  input  coord_t                in_center_y,
  input  logic [SIZE_BITS-1:0]  in_box_width,
  input  logic [SIZE_BITS-1:0]  in_box_height,
  input  logic [IDX_BITS-1:0]   in_range_first,
  input  logic [IDX_BITS-1:0]   in_range_last,
  output logic                  out_strobe,
  output logic                  out_placed,
  output coord_t                out_left_edge,
  output coord_t                out_bottom_edge,
  output coord_t                out_right_edge,
  output coord_t                out_top_edge
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  bpoc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd),
    .sts        (sts)
  );

  bpoc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_entry_index  (in_entry_index),
    .in_center_x     (in_center_x),
    .in_center_y     (in_center_y),
    .in_box_width    (in_box_width),
    .in_box_height   (in_box_height),
    .in_range_first  (in_range_first),
    .in_range_last   (in_range_last),
    .out_placed      (out_placed),
    .out_left_edge   (out_left_edge),
    .out_bottom_edge (out_bottom_edge),
    .out_right_edge  (out_right_edge),
    .out_top_edge    (out_top_edge)
  );

endmodule

[verif/box_placement_overlap_check_unit_test.sv]
module box_placement_overlap_check_unit_test;
  import bpoc_pkg::*;

  localparam int TABLE_DEPTH = 128;
  localparam int DRAIN_CYCLES = 140;

  typedef struct {
    logic   placed;
    coord_t left;
    coord_t bottom;
    coord_t right;
    coord_t top;
  } placement_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [IDX_BITS-1:0]  in_entry_index = '0;
  coord_t               in_center_x = '0;
  coord_t               in_center_y = '0;
  logic [SIZE_BITS-1:0] in_box_width = '0;
  logic [SIZE_BITS-1:0] in_box_height = '0;
  logic [IDX_BITS-1:0]  in_range_first = '0;
  logic [IDX_BITS-1:0]  in_range_last = '0;
  logic                 out_strobe;
  logic                 out_placed;
  coord_t               out_left_edge;
  coord_t               out_bottom_edge;
  coord_t               out_right_edge;
  coord_t               out_top_edge;

  box_t       shadow_boxes [TABLE_DEPTH];
  placement_t pending_results[$];
  int         words_sent = 0;
  int         placed_seen = 0;
  int         rejected_seen = 0;
  int         mismatches = 0;

  box_placement_overlap_check_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_entry_index  (in_entry_index),
    .in_center_x     (in_center_x),
    .in_center_y     (in_center_y),
    .in_box_width    (in_box_width),
    .in_box_height   (in_box_height),
    .in_range_first  (in_range_first),
    .in_range_last   (in_range_last),
    .out_strobe      (out_strobe),
    .out_placed      (out_placed),
    .out_left_edge   (out_left_edge),
    .out_bottom_edge (out_bottom_edge),
    .out_right_edge  (out_right_edge),
    .out_top_edge    (out_top_edge)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic coord_t clamp_coord(int v);
    int hi;
    int lo;
    hi = (1 << (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return coord_t'(hi);
    end else if (v < lo) begin
      return coord_t'(lo);
    end
    return coord_t'(v);
  endfunction

  // Works out the edges of the proposed box, scans the range against the shadow
  // table and stores the box when nothing in the range overlaps it.
  function automatic placement_t predict_placement(
    logic [IDX_BITS-1:0] entry, coord_t cx, coord_t cy,
    logic [SIZE_BITS-1:0] w, logic [SIZE_BITS-1:0] h,
    logic [IDX_BITS-1:0] first, logic [IDX_BITS-1:0] last
  );
    placement_t res;
    int         slot;
    int         nl, nr, nb, nt;
    logic       hit;
    logic       x_apart, y_apart;
    slot = int'(entry) % TABLE_DEPTH;
    res.left   = clamp_coord(int'(cx) - int'(w >> 1));
    res.right  = clamp_coord(int'(cx) + int'(w >> 1));
    res.bottom = clamp_coord(int'(cy) - int'(h >> 1));
    res.top    = clamp_coord(int'(cy) + int'(h >> 1));
    nl = int'(res.left);
    nr = int'(res.right);
    nb = int'(res.bottom);
    nt = int'(res.top);
    hit = 1'b0;
    for (int i = int'(first); i <= int'(last) && i < TABLE_DEPTH; i++) begin
      if (i != slot) begin
        x_apart = (nl < int'(shadow_boxes[i].left) && nr < int'(shadow_boxes[i].left)) ||
                  (nl > int'(shadow_boxes[i].right) && nr > int'(shadow_boxes[i].right));
        y_apart = (nb < int'(shadow_boxes[i].bottom) && nt < int'(shadow_boxes[i].bottom)) ||
                  (nb > int'(shadow_boxes[i].top) && nt > int'(shadow_boxes[i].top));
        // Touching edges are not apart, so they count as a hit.
        if (!x_apart && !y_apart) begin
          hit = 1'b1;
          break;
        end
      end
    end
    if (!hit) begin
      shadow_boxes[slot].left   = res.left;
      shadow_boxes[slot].bottom = res.bottom;
      shadow_boxes[slot].right  = res.right;
      shadow_boxes[slot].top    = res.top;
    end
    res.placed = !hit;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Leaves start high on return so that a following word needs no second write to it.
  task automatic send_word(
    logic [IDX_BITS-1:0] entry, coord_t cx, coord_t cy,
    logic [SIZE_BITS-1:0] w, logic [SIZE_BITS-1:0] h,
    logic [IDX_BITS-1:0] first, logic [IDX_BITS-1:0] last
  );
    start          <= 1'b1;
    in_entry_index <= entry;
    in_center_x    <= cx;
    in_center_y    <= cy;
    in_box_width   <= w;
    in_box_height  <= h;
    in_range_first <= first;
    in_range_last  <= last;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_placement(entry, cx, cy, w, h, first, last));
    words_sent++;
  endtask

  task automatic idle_gap(int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(40, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  always @(posedge clk) begin
    placement_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with no word pending");
      end else begin
        want = pending_results.pop_front();
        if (out_placed !== want.placed)
          report_mismatch($sformatf("placed %b, want %b", out_placed, want.placed));
        if (out_left_edge !== want.left)
          report_mismatch($sformatf("left %0d, want %0d", out_left_edge, want.left));
        if (out_bottom_edge !== want.bottom)
          report_mismatch($sformatf("bottom %0d, want %0d", out_bottom_edge, want.bottom));
        if (out_right_edge !== want.right)
          report_mismatch($sformatf("right %0d, want %0d", out_right_edge, want.right));
        if (out_top_edge !== want.top)
          report_mismatch($sformatf("top %0d, want %0d", out_top_edge, want.top));
        if (want.placed) begin
          placed_seen++;
        end else begin
          rejected_seen++;
        end
      end
    end
  end

  // A cleared table holds point boxes at the origin, which still take part in the test.
  task automatic test_cleared_table();
    send_word(7'd5, 16'sd100, 16'sd100, 15'd16, 15'd16, 7'd0, 7'd127);
    send_word(7'd6, 16'sd0, 16'sd0, 15'd2, 15'd2, 7'd0, 7'd4);
    send_word(7'd9, -16'sd40, 16'sd40, 15'd0, 15'd0, 7'd127, 7'd127);
  endtask

  task automatic test_empty_and_self_ranges();
    send_word(7'd7, 16'sd0, 16'sd0, 15'd32767, 15'd32767, 7'd100, 7'd99);
    send_word(7'd8, 16'sd0, 16'sd0, 15'd32767, 15'd32767, 7'd127, 7'd0);
    send_word(7'd7, 16'sd0, 16'sd0, 15'd32767, 15'd32767, 7'd7, 7'd7);
    send_word(7'd7, 16'sd0, 16'sd0, 15'd32767, 15'd32767, 7'd5, 7'd7);
  endtask

  task automatic test_saturated_edges();
    send_word(7'd127, 16'sd32767, -16'sd32768, 15'd32767, 15'd32767, 7'd127, 7'd127);
    send_word(7'd0, -16'sd32768, 16'sd32767, 15'd32767, 15'd32767, 7'd1, 7'd1);
    send_word(7'd126, 16'sd32767, 16'sd32767, 15'd32766, 15'd1, 7'd0, 7'd127);
  endtask

  task automatic test_touching_edges();
    send_word(7'd10, 16'sd1000, 16'sd1000, 15'd32, 15'd32, 7'd10, 7'd10);
    send_word(7'd11, 16'sd1032, 16'sd1000, 15'd32, 15'd32, 7'd10, 7'd10);
    send_word(7'd11, 16'sd1033, 16'sd1000, 15'd33, 15'd32, 7'd10, 7'd10);
    send_word(7'd12, 16'sd1000, 16'sd968, 15'd32, 15'd32, 7'd10, 7'd11);
    send_word(7'd12, 16'sd1000, 16'sd967, 15'd32, 15'd33, 7'd10, 7'd11);
    // Corner contact with entry 10, edge contact with entry 12.
    send_word(7'd13, 16'sd968, 16'sd968, 15'd32, 15'd32, 7'd10, 7'd12);
    send_word(7'd20, -16'sd500, -16'sd500, 15'd0, 15'd0, 7'd0, 7'd127);
    wait_drained();
  endtask

  task automatic test_random_traffic(int count, int idle_pct);
    logic [IDX_BITS-1:0]  entry, first, last;
    coord_t               cx, cy;
    logic [SIZE_BITS-1:0] w, h;
    int                   kind;
    for (int n = 0; n < count; n++) begin
      kind  = $urandom_range(99);
      entry = IDX_BITS'($urandom);
      if (kind < 65) begin
        // Well-formed placements: small boxes scattered so that many fit.
        cx = coord_t'((int'($urandom_range(63)) - 32) * 512 + int'($urandom_range(511)));
        cy = coord_t'((int'($urandom_range(63)) - 32) * 512 + int'($urandom_range(511)));
        w  = SIZE_BITS'($urandom_range(600));
        h  = SIZE_BITS'($urandom_range(600));
        if ($urandom_range(9) == 0) begin
          first = '0;
          last  = '1;
        end else begin
          first = IDX_BITS'($urandom);
          last  = (int'(first) + $urandom_range(48) > 127) ? 7'd127
                                                             : first + IDX_BITS'($urandom_range(48));
        end
      end else begin
        cx = coord_t'($urandom);
        cy = coord_t'($urandom);
        w  = SIZE_BITS'($urandom);
        h  = SIZE_BITS'($urandom);
        if (kind < 85) begin
          first = IDX_BITS'($urandom);
          last  = IDX_BITS'($urandom);
        end else if (kind < 93) begin
          first = IDX_BITS'($urandom_range(127, 1));
          last  = IDX_BITS'($urandom_range(int'(first) - 1));
        end else begin
          first = entry;
          last  = entry;
        end
      end
      send_word(entry, cx, cy, w, h, first, last);
      idle_gap(idle_pct);
    end
  endtask

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) shadow_boxes[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cleared_table();
    test_empty_and_self_ranges();
    test_saturated_edges();
    test_touching_edges();
    test_random_traffic(200, 22);
    wait_drained();
    test_random_traffic(200, 78);
    wait_drained();
    test_random_traffic(200, 0);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d words: %0d boxes stored, %0d rejected for overlap",
             words_sent, placed_seen, rejected_seen);
    $display("directed edge, range and saturation cases, then three idling mixes");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d words still pending", pending_results.size());
    $display("FAIL");
    $finish;
  end

endmodule
